// ===== src/bpc_pkg.sv =====
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// bpc_pkg
// Shared types and constants of the button press classifier.
// ----------------------------------------------------------------------------
package bpc_pkg;

  localparam int unsigned TimeW  = 32;
  localparam int unsigned MsW    = 16;
  localparam int unsigned AddrW  = 4;
  localparam int unsigned DataW  = 32;

  // register indexes
  localparam logic [1:0] RegDebounce = 2'd0;
  localparam logic [1:0] RegLong     = 2'd1;
  localparam logic [1:0] RegDouble   = 2'd2;

  localparam logic [MsW-1:0] DebounceRst = 16'd50;
  localparam logic [MsW-1:0] LongRst     = 16'd1000;
  localparam logic [MsW-1:0] DoubleRst   = 16'd500;

  typedef enum logic [1:0] {
    KIND_SINGLE = 2'd0,
    KIND_DOUBLE = 2'd1,
    KIND_LONG   = 2'd2
  } press_kind_e;

  typedef struct packed {
    logic [MsW-1:0] debounce_ms;
    logic [MsW-1:0] long_press_ms;
    logic [MsW-1:0] double_press_ms;
  } bpc_cfg_t;

  typedef struct packed {
    logic           window_running;
    logic [MsW-1:0] window_left;
  } bpc_status_t;

endpackage

// ===== src/bpc_in_if.sv =====
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// bpc_in_if
// Input channel: one tick or one pin edge per transfer.
// ----------------------------------------------------------------------------
interface bpc_in_if;
  logic valid;
  logic ready;
  logic req_type;
  logic pin_level;

  modport source (output valid, output req_type, output pin_level, input ready);
  modport sink   (input valid, input req_type, input pin_level, output ready);
endinterface

// ===== src/bpc_out_if.sv =====
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// bpc_out_if
// Result channel: one classified press per transfer.
// ----------------------------------------------------------------------------
interface bpc_out_if;
  logic                     valid;
  logic                     ready;
  bpc_pkg::press_kind_e     press_kind;

  modport source (output valid, output press_kind, input ready);
  modport sink   (input valid, input press_kind, output ready);
endinterface

// ===== src/bpc_cfg.sv =====
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// bpc_cfg
// APB register file holding the debounce, long press and double press times.
// ----------------------------------------------------------------------------
module bpc_cfg (
  input  logic                          clk_i,
  input  logic                          rst_ni,
  input  logic                          psel,
  input  logic                          penable,
  input  logic                          pwrite,
  input  logic [bpc_pkg::AddrW-1:0]     paddr,
  input  logic [bpc_pkg::DataW-1:0]     pwdata,
  output logic [bpc_pkg::DataW-1:0]     prdata,
  output logic                          pready,
  output bpc_pkg::bpc_cfg_t             cfg_o
);
  import bpc_pkg::*;

  bpc_cfg_t   cfg_q;
  logic       wr_en;
  logic [1:0] idx;

  assign pready = 1'b1;
  assign idx    = paddr[AddrW-1:2];
  assign wr_en  = psel & penable & pwrite & pready;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      cfg_q.debounce_ms     <= DebounceRst;
      cfg_q.long_press_ms   <= LongRst;
      cfg_q.double_press_ms <= DoubleRst;
    end else if (wr_en) begin
      case (idx)
        RegDebounce: cfg_q.debounce_ms     <= pwdata[MsW-1:0];
        RegLong:     cfg_q.long_press_ms   <= pwdata[MsW-1:0];
        RegDouble:   cfg_q.double_press_ms <= pwdata[MsW-1:0];
        default: ;
      endcase
    end
  end

  always_comb begin
    case (idx)
      RegDebounce: prdata = {{(DataW-MsW){1'b0}}, cfg_q.debounce_ms};
      RegLong:     prdata = {{(DataW-MsW){1'b0}}, cfg_q.long_press_ms};
      RegDouble:   prdata = {{(DataW-MsW){1'b0}}, cfg_q.double_press_ms};
      default:     prdata = '0;
    endcase
  end

  assign cfg_o = cfg_q;

endmodule

// ===== src/bpc_core.sv =====
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// bpc_core
// Input register, single pass classification and result register.
// ----------------------------------------------------------------------------
module bpc_core (
  input  logic                 clk_i,
  input  logic                 rst_ni,
  input  bpc_pkg::bpc_cfg_t    cfg_i,
  bpc_in_if.sink               in_i,
  bpc_out_if.source            out_o,
  output bpc_pkg::bpc_status_t status_o
);
  import bpc_pkg::*;

  // input stage
  logic s1_valid_q;
  logic req_type_q;
  logic pin_level_q;
  logic s1_adv;

  // classifier state
  logic [TimeW-1:0] time_now_q, time_now_d;
  logic [TimeW-1:0] last_edge_q, last_edge_d;
  logic [TimeW-1:0] press_start_q, press_start_d;
  logic             first_rel_q, first_rel_d;
  logic [MsW-1:0]   win_left_q, win_left_d;
  logic             win_run_q, win_run_d;

  // result stage
  logic        out_valid_q;
  press_kind_e kind_q;
  logic        emit;
  press_kind_e kind;

  logic [TimeW-1:0] since_edge;
  logic [TimeW-1:0] hold_time;

  assign s1_adv   = !out_valid_q || out_o.ready;
  assign in_i.ready = !s1_valid_q || s1_adv;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      s1_valid_q <= 1'b0;
    end else if (in_i.ready) begin
      s1_valid_q <= in_i.valid;
    end
  end

  always_ff @(posedge clk_i) begin
    if (in_i.ready && in_i.valid) begin
      req_type_q  <= in_i.req_type;
      pin_level_q <= in_i.pin_level;
    end
  end

  assign since_edge = time_now_q - last_edge_q;
  assign hold_time  = time_now_q - press_start_q;

  always_comb begin
    time_now_d    = time_now_q;
    last_edge_d   = last_edge_q;
    press_start_d = press_start_q;
    first_rel_d   = first_rel_q;
    win_left_d    = win_left_q;
    win_run_d     = win_run_q;
    emit          = 1'b0;
    kind          = KIND_SINGLE;
    if (s1_valid_q && s1_adv) begin
      if (!req_type_q) begin
        // tick: time first, then the window
        time_now_d = time_now_q + 1'b1;
        if (win_run_q) begin
          if (win_left_q <= MsW'(1)) begin
            win_left_d  = '0;
            win_run_d   = 1'b0;
            first_rel_d = 1'b0;
            emit        = 1'b1;
            kind        = KIND_SINGLE;
          end else begin
            win_left_d = win_left_q - 1'b1;
          end
        end
      end else if (since_edge >= {{(TimeW-MsW){1'b0}}, cfg_i.debounce_ms}) begin
        last_edge_d = time_now_q;
        if (pin_level_q) begin
          press_start_d = time_now_q;
        end else if (hold_time > {{(TimeW-MsW){1'b0}}, cfg_i.long_press_ms}) begin
          first_rel_d = 1'b0;
          emit        = 1'b1;
          kind        = KIND_LONG;
        end else if (first_rel_q) begin
          first_rel_d = 1'b0;
          win_run_d   = 1'b0;
          win_left_d  = '0;
          emit        = 1'b1;
          kind        = KIND_DOUBLE;
        end else begin
          first_rel_d = 1'b1;
          win_left_d  = cfg_i.double_press_ms;
          win_run_d   = 1'b1;
        end
      end
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      time_now_q    <= '0;
      last_edge_q   <= '0;
      press_start_q <= '0;
      first_rel_q   <= 1'b0;
      win_left_q    <= '0;
      win_run_q     <= 1'b0;
      out_valid_q   <= 1'b0;
    end else begin
      time_now_q    <= time_now_d;
      last_edge_q   <= last_edge_d;
      press_start_q <= press_start_d;
      first_rel_q   <= first_rel_d;
      win_left_q    <= win_left_d;
      win_run_q     <= win_run_d;
      if (s1_adv) begin
        out_valid_q <= s1_valid_q && emit;
      end
    end
  end

  always_ff @(posedge clk_i) begin
    if (s1_adv && emit) begin
      kind_q <= kind;
    end
  end

  assign out_o.valid      = out_valid_q;
  assign out_o.press_kind = kind_q;

  assign status_o.window_running = win_run_q;
  assign status_o.window_left    = win_left_q;

endmodule

// ===== src/button_press_classifier.sv =====
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// button_press_classifier
// Debounces one button and reports single, double and long presses.
// ----------------------------------------------------------------------------
// Takes one item (a millisecond tick or a pin edge) every clock cycle while
// the result channel is not stalled. An item is registered on acceptance
// and then classified by one compare-and-update pass over the timing state,
// which loads the result register; a press reaches the result channel from
// there. A stalled result holds the pipeline until taken. Times are kept in
// 32-bit millisecond counters that wrap. Registers at byte address 0, 4 and
// 8: debounce_ms, long_press_ms, double_press_ms.
module button_press_classifier (
  input  logic                      clk_i,
  input  logic                      rst_ni,
  input  logic                      psel,
  input  logic                      penable,
  input  logic                      pwrite,
  input  logic [bpc_pkg::AddrW-1:0] paddr,
  input  logic [bpc_pkg::DataW-1:0] pwdata,
  output logic [bpc_pkg::DataW-1:0] prdata,
  output logic                      pready,
  bpc_in_if.sink                    in_i,
  bpc_out_if.source                 out_o
);
  import bpc_pkg::*;

  bpc_cfg_t    cfg;
  bpc_status_t status;

  bpc_cfg u_cfg (
    .clk_i   (clk_i),
    .rst_ni  (rst_ni),
    .psel    (psel),
    .penable (penable),
    .pwrite  (pwrite),
    .paddr   (paddr),
    .pwdata  (pwdata),
    .prdata  (prdata),
    .pready  (pready),
    .cfg_o   (cfg)
  );

  bpc_core u_core (
    .clk_i    (clk_i),
    .rst_ni   (rst_ni),
    .cfg_i    (cfg),
    .in_i     (in_i),
    .out_o    (out_o),
    .status_o (status)
  );

  // a stopped window is always cleared
  a_win_idle : assert property (@(posedge clk_i) disable iff (!rst_ni)
    !status.window_running |-> status.window_left == '0)
    else $error("window stopped with time left");

  // an empty result register never blocks the input
  a_no_stall : assert property (@(posedge clk_i) disable iff (!rst_ni)
    !out_o.valid |-> in_i.ready)
    else $error("input stalled with empty result register");

  // arming loads the double press window
  a_arm : assert property (@(posedge clk_i) disable iff (!rst_ni)
    $rose(status.window_running) |-> status.window_left == cfg.double_press_ms)
    else $error("window armed with wrong length");

endmodule

// ===== test/button_press_classifier_test.sv =====
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// button_press_classifier_test
// Self-checking bench for the button press classifier. Ticks and pin edges
// go in through the input channel with random gaps. Classified presses are
// taken with random back-pressure and compared in order against a local
// debounce and press-timing predictor. The bench steps through several
// register settings over the APB port, the extremes among them.
// ----------------------------------------------------------------------------
module button_press_classifier_test;
  import bpc_pkg::*;

  localparam logic REQ_TICK     = 1'b0;
  localparam logic REQ_EDGE     = 1'b1;
  localparam logic LVL_RELEASED = 1'b0;
  localparam logic LVL_PRESSED  = 1'b1;

  typedef struct packed {
    logic req_type;
    logic pin_level;
  } pin_item_t;

  logic             clk_i = 1'b0;
  logic             rst_ni;
  logic             psel;
  logic             penable;
  logic             pwrite;
  logic [AddrW-1:0] paddr;
  logic [DataW-1:0] pwdata;
  logic [DataW-1:0] prdata;
  logic             pready;

  bpc_in_if  in_if ();
  bpc_out_if out_if ();

  button_press_classifier u_top (
    .clk_i   (clk_i),
    .rst_ni  (rst_ni),
    .psel    (psel),
    .penable (penable),
    .pwrite  (pwrite),
    .paddr   (paddr),
    .pwdata  (pwdata),
    .prdata  (prdata),
    .pready  (pready),
    .in_i    (in_if),
    .out_o   (out_if)
  );

  always #5 clk_i = ~clk_i;

  // predictor state and register copy
  bpc_cfg_t         cfg;
  logic [TimeW-1:0] now_ms;
  logic [TimeW-1:0] last_edge_ms;
  logic [TimeW-1:0] press_start_ms;
  logic             release_pending;
  logic [MsW-1:0]   window_ms;
  logic             window_on;

  pin_item_t   pin_item_q[$];
  press_kind_e press_due_q[$];
  pin_item_t   cur_item;
  press_kind_e pred_kind;
  press_kind_e due_kind;
  int unsigned in_gap;
  int unsigned out_stall;
  int unsigned items_taken;
  int unsigned fail_cnt;
  bit          calm;

  function automatic bit classify_item(input logic req_type, input logic pin_level,
                                       output press_kind_e kind);
    kind = KIND_SINGLE;
    if (req_type == REQ_TICK) begin
      now_ms = now_ms + 32'd1;
      if (window_on) begin
        if (window_ms <= 16'd1) begin
          window_ms       = '0;
          window_on       = 1'b0;
          release_pending = 1'b0;
          return 1'b1;
        end
        window_ms = window_ms - 16'd1;
      end
      return 1'b0;
    end
    if ((now_ms - last_edge_ms) < TimeW'(cfg.debounce_ms)) return 1'b0;
    last_edge_ms = now_ms;
    if (pin_level == LVL_PRESSED) begin
      press_start_ms = now_ms;
      return 1'b0;
    end
    if ((now_ms - press_start_ms) > TimeW'(cfg.long_press_ms)) begin
      release_pending = 1'b0;
      kind            = KIND_LONG;
      return 1'b1;
    end
    if (release_pending) begin
      release_pending = 1'b0;
      window_on       = 1'b0;
      window_ms       = '0;
      kind            = KIND_DOUBLE;
      return 1'b1;
    end
    release_pending = 1'b1;
    window_ms       = cfg.double_press_ms;
    window_on       = 1'b1;
    return 1'b0;
  endfunction

  function automatic int unsigned pick_gap();
    int unsigned r;
    r = $urandom_range(0, 99);
    if (r < 80) return $urandom_range(1, 3);
    if (r < 95) return $urandom_range(4, 10);
    return $urandom_range(20, 60);
  endfunction

  task automatic note_error(input string what);
    fail_cnt++;
    if (fail_cnt <= 10) $display("mismatch: %s", what);
  endtask

  // input driver
  always @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      in_if.valid     <= 1'b0;
      in_if.req_type  <= REQ_TICK;
      in_if.pin_level <= LVL_RELEASED;
      in_gap          <= 0;
    end else begin
      if (in_if.valid && in_if.ready) begin
        items_taken++;
        if (classify_item(in_if.req_type, in_if.pin_level, pred_kind))
          press_due_q.push_back(pred_kind);
      end
      if (!in_if.valid || in_if.ready) begin
        if (in_gap != 0) begin
          in_gap      <= in_gap - 1;
          in_if.valid <= 1'b0;
        end else if (pin_item_q.size() != 0) begin
          cur_item        = pin_item_q.pop_front();
          in_if.valid     <= 1'b1;
          in_if.req_type  <= cur_item.req_type;
          in_if.pin_level <= cur_item.pin_level;
          in_gap          <= (calm || $urandom_range(0, 2) != 0) ? 0 : pick_gap();
        end else begin
          in_if.valid <= 1'b0;
        end
      end
    end
  end

  // result monitor
  always @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      out_if.ready <= 1'b0;
      out_stall    <= 0;
    end else begin
      if (out_if.valid && out_if.ready) begin
        if (press_due_q.size() == 0) begin
          note_error($sformatf("press kind %0d with none expected", out_if.press_kind));
        end else begin
          due_kind = press_due_q.pop_front();
          if (out_if.press_kind !== due_kind)
            note_error($sformatf("press kind expected %0d got %0d",
                                 due_kind, out_if.press_kind));
        end
      end
      if (out_stall != 0) begin
        out_stall    <= out_stall - 1;
        out_if.ready <= 1'b0;
      end else if (!calm && $urandom_range(0, 4) == 0) begin
        out_stall    <= pick_gap() - 1;
        out_if.ready <= 1'b0;
      end else begin
        out_if.ready <= 1'b1;
      end
    end
  end

  task automatic add_item(input logic req_type, input logic pin_level);
    pin_item_q.push_back('{req_type: req_type, pin_level: pin_level});
  endtask

  task automatic add_ticks(input int unsigned n);
    repeat (n) add_item(REQ_TICK, 1'($urandom_range(0, 1)));
  endtask

  task automatic settle();
    do @(posedge clk_i);
    while (pin_item_q.size() != 0 || in_if.valid || press_due_q.size() != 0);
    repeat (6) @(posedge clk_i);
    while (press_due_q.size() != 0 || out_if.valid) @(posedge clk_i);
  endtask

  task automatic write_reg(input logic [1:0] idx, input logic [MsW-1:0] val);
    @(posedge clk_i);
    psel    <= 1'b1;
    penable <= 1'b0;
    pwrite  <= 1'b1;
    paddr   <= {idx, 2'b00};
    pwdata  <= {16'd0, val};
    @(posedge clk_i);
    penable <= 1'b1;
    @(posedge clk_i);
    psel    <= 1'b0;
    penable <= 1'b0;
    pwrite  <= 1'b0;
    case (idx)
      RegDebounce: cfg.debounce_ms     = val;
      RegLong:     cfg.long_press_ms   = val;
      RegDouble:   cfg.double_press_ms = val;
      default: ;
    endcase
  endtask

  task automatic write_all(input logic [MsW-1:0] deb, input logic [MsW-1:0] lng,
                           input logic [MsW-1:0] dbl);
    write_reg(RegDebounce, deb);
    write_reg(RegLong, lng);
    write_reg(RegDouble, dbl);
  endtask

  // press/release runs sized around the current timings, some with bounce
  task automatic add_presses(input int unsigned runs);
    int unsigned k;
    int unsigned settle_ms;
    int unsigned hold;
    int unsigned gap;
    for (int unsigned i = 0; i < runs; i++) begin
      settle_ms = (cfg.debounce_ms <= 8) ? cfg.debounce_ms : 0;
      hold = settle_ms + $urandom_range(0, (cfg.long_press_ms < 30) ?
                                           cfg.long_press_ms + 3 : 30);
      gap  = settle_ms + $urandom_range(0, (cfg.double_press_ms < 30) ?
                                           cfg.double_press_ms + 3 : 30);
      k = $urandom_range(0, 9);
      if (k == 9) begin
        repeat ($urandom_range(4, 12))
          add_item(1'($urandom_range(0, 1)), 1'($urandom_range(0, 1)));
      end else begin
        add_item(REQ_EDGE, LVL_PRESSED);
        if (k == 8) begin
          add_item(REQ_EDGE, LVL_RELEASED);
          add_item(REQ_EDGE, LVL_PRESSED);
        end
        add_ticks(hold);
        add_item(REQ_EDGE, LVL_RELEASED);
        add_ticks(gap);
      end
    end
  endtask

  initial begin
    int unsigned mode;
    logic [MsW-1:0] deb;
    logic [MsW-1:0] lng;
    logic [MsW-1:0] dbl;
    rst_ni           = 1'b0;
    psel             = 1'b0;
    penable          = 1'b0;
    pwrite           = 1'b0;
    paddr            = '0;
    pwdata           = '0;
    cfg              = '{debounce_ms: DebounceRst, long_press_ms: LongRst,
                         double_press_ms: DoubleRst};
    now_ms           = '0;
    last_edge_ms     = '0;
    press_start_ms   = '0;
    release_pending  = 1'b0;
    window_ms        = '0;
    window_on        = 1'b0;
    items_taken      = 0;
    fail_cnt         = 0;
    calm             = 1'b0;
    repeat (4) @(posedge clk_i);
    rst_ni <= 1'b1;

    // reset timings: early edges ignored, bounce inside debounce, double press
    add_item(REQ_EDGE, LVL_PRESSED);
    add_ticks(3);
    add_item(REQ_EDGE, LVL_RELEASED);
    add_ticks(50);
    add_item(REQ_EDGE, LVL_PRESSED);
    add_ticks(49);
    add_item(REQ_EDGE, LVL_RELEASED);
    add_ticks(1);
    add_item(REQ_EDGE, LVL_RELEASED);
    add_ticks(60);
    add_item(REQ_EDGE, LVL_PRESSED);
    add_ticks(60);
    add_item(REQ_EDGE, LVL_RELEASED);
    settle();

    // single, double and long press
    write_all(16'd0, 16'd4, 16'd3);
    add_item(REQ_EDGE, LVL_PRESSED);
    add_ticks(2);
    add_item(REQ_EDGE, LVL_RELEASED);
    add_ticks(3);
    add_item(REQ_EDGE, LVL_PRESSED);
    add_ticks(1);
    add_item(REQ_EDGE, LVL_RELEASED);
    add_ticks(1);
    add_item(REQ_EDGE, LVL_PRESSED);
    add_ticks(1);
    add_item(REQ_EDGE, LVL_RELEASED);
    add_item(REQ_EDGE, LVL_PRESSED);
    add_ticks(5);
    add_item(REQ_EDGE, LVL_RELEASED);
    settle();

    // long press while the window runs, then re-arm of the running window
    write_all(16'd0, 16'd0, 16'd2);
    add_item(REQ_EDGE, LVL_PRESSED);
    add_item(REQ_EDGE, LVL_RELEASED);
    add_item(REQ_EDGE, LVL_PRESSED);
    add_ticks(1);
    add_item(REQ_EDGE, LVL_RELEASED);
    add_item(REQ_EDGE, LVL_PRESSED);
    add_item(REQ_EDGE, LVL_RELEASED);
    add_ticks(2);
    settle();

    // zero window expires on the next tick
    write_reg(RegDouble, 16'd0);
    add_item(REQ_EDGE, LVL_PRESSED);
    add_item(REQ_EDGE, LVL_RELEASED);
    add_ticks(1);
    settle();

    while (items_taken < 850) begin
      mode = $urandom_range(0, 9);
      calm = ($urandom_range(0, 3) == 0);
      case (mode)
        0: begin
          deb = 16'd0;
          lng = 16'd0;
          dbl = 16'd0;
        end
        1: begin
          deb = 16'hFFFF;
          lng = MsW'($urandom_range(0, 20));
          dbl = MsW'($urandom_range(0, 20));
        end
        2: begin
          deb = MsW'($urandom_range(0, 3));
          lng = 16'hFFFF;
          dbl = 16'hFFFF;
        end
        default: begin
          deb = MsW'($urandom_range(0, 4));
          lng = MsW'($urandom_range(0, 25));
          dbl = MsW'($urandom_range(0, 20));
        end
      endcase
      write_all(deb, lng, dbl);
      add_presses((mode == 1) ? 2 : $urandom_range(4, 10));
      settle();
    end

    if (fail_cnt == 0) begin
      $display("TB_OK");
    end else begin
      $display("TB_ERROR");
    end
    $finish;
  end

  initial begin
    #10_000_000;
    $display("TB_ERROR");
    $finish;
  end

endmodule
